FILE: sv/basic_line_tokenizer_core_defines.svh
// assertion macros for the tokenizer core rtl
`ifndef BASIC_LINE_TOKENIZER_CORE_DEFINES_SVH
`define BASIC_LINE_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define BLT_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define BLT_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: sv/blt_pkg.sv
// shared types, codes and helpers for the line tokenizer
`default_nettype none

package blt_pkg;

    localparam int DEF_MAX_TOKENS = 64;
    localparam int DEF_MAX_TEXT   = 255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_LETTER,
        MODE_WORD,
        MODE_STRING,
        MODE_LT,
        MODE_GT
    } lex_mode_t;

    localparam logic [4:0] KIND_NUMBER = 5'd0;
    localparam logic [4:0] KIND_VAR    = 5'd1;
    localparam logic [4:0] KIND_PLUS   = 5'd2;
    localparam logic [4:0] KIND_MINUS  = 5'd3;
    localparam logic [4:0] KIND_STAR   = 5'd4;
    localparam logic [4:0] KIND_SLASH  = 5'd5;
    localparam logic [4:0] KIND_LPAREN = 5'd6;
    localparam logic [4:0] KIND_RPAREN = 5'd7;
    localparam logic [4:0] KIND_EQ     = 5'd8;
    localparam logic [4:0] KIND_LT     = 5'd9;
    localparam logic [4:0] KIND_GT     = 5'd10;
    localparam logic [4:0] KIND_LE     = 5'd11;
    localparam logic [4:0] KIND_GE     = 5'd12;
    localparam logic [4:0] KIND_NE     = 5'd13;
    localparam logic [4:0] KIND_COMMA  = 5'd14;
    localparam logic [4:0] KIND_SEMI   = 5'd15;
    localparam logic [4:0] KIND_STRING = 5'd16;
    localparam logic [4:0] KIND_EOL    = 5'd17;
    localparam logic [4:0] KIND_WORD   = 5'd18;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [7:0]  text_char;
        logic        has_char;
        logic        token_last;
        logic        line_last;
    } token_res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LO_A) && (c <= CH_LO_Z);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || is_upper(c) || is_lower(c);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return is_lower(c) ? 8'(c - CASE_GAP) : c;
    endfunction

    // single-character operators; anything else maps to KIND_WORD
    function automatic logic [4:0] op_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_EQ:     k = KIND_EQ;
            CH_COMMA:  k = KIND_COMMA;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_WORD;
        endcase
        return k;
    endfunction

    function automatic token_res_t make_res(input logic [4:0] kind, input logic [31:0] value,
                                            input logic [7:0] c, input logic has,
                                            input logic tl, input logic ll);
        token_res_t r;
        r.kind       = kind;
        r.value      = value;
        r.text_char  = has ? c : 8'd0;
        r.has_char   = has;
        r.token_last = tl;
        r.line_last  = ll;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/blt_out_queue.sv
// small result queue taking up to two results per cycle and giving one
`default_nettype none

module blt_out_queue import blt_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] push_cnt,
    input  wire token_res_t push0,
    input  wire token_res_t push1,
    output logic            space2,
    output token_res_t      head,
    output logic            head_vld,
    input  wire logic       pop
);

    localparam int CW = QUEUE_AW + 1;

    token_res_t          mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [QUEUE_AW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_AW'(1);
    assign wr_ptr_next  = wr_ptr_reg + QUEUE_AW'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + QUEUE_AW'(pop);
    assign count_next   = count_reg + CW'(push_cnt) - CW'(pop);

    assign space2   = count_reg <= CW'(QUEUE_DEPTH - 2);
    assign head_vld = count_reg != '0;
    assign head     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_ptr_plus1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/basic_line_tokenizer_core.sv
// Streaming lexer for one line of a small BASIC dialect.
// Input channel s_*: one character per transfer in s_tdata[7:0]; a zero byte
// ends the line. Result channel m_*: one token result per transfer, with
// value and text character in m_tdata, kind/has_char/token_last in m_tuser
// and the end-of-line marker on m_tlast. Words and strings stream one
// character per result, delayed by one held character of lookahead.
// Each accepted character yields zero, one or two results. The lexer state
// updates in the accept cycle and the results are written into a 4-entry
// queue, whose head drives m_*.
// Throughput is one character per cycle while the queue has room for two
// results; a character that makes two results needs two output transfers,
// so the output port sets the sustained rate.
// s_tready depends only on the queue fill, never on m_tready directly. When
// the receiver stalls, results wait in the queue and s_tready drops once
// fewer than two entries are free.
// Reset (aresetn low, synchronous) empties the queue and returns the lexer to
// idle between tokens with zero token count.
`default_nettype none

module basic_line_tokenizer_core import blt_pkg::*; #(
    parameter int MAX_TOKENS = DEF_MAX_TOKENS,
    parameter int MAX_TEXT   = DEF_MAX_TEXT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] value, [39:32] text_char
    output logic [6:0]       m_tuser,   // [4:0] kind, [5] has_char, [6] token_last
    output logic             m_tlast    // line_last
);

`include "basic_line_tokenizer_core_defines.svh"

    localparam logic [6:0] TOKEN_CAP = 7'(MAX_TOKENS);
    localparam logic [7:0] TEXT_CAP  = 8'(MAX_TEXT);

    lex_mode_t   mode_reg, mode_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  held_reg, held_next;
    logic [7:0]  tlen_reg, tlen_next;
    logic [6:0]  ttotal_reg, ttotal_next;

    logic        s_fire;
    logic [7:0]  ch;
    logic [7:0]  eff_len;
    logic        fresh;
    logic        res_a_vld, res_b_vld;
    token_res_t  res_a, res_b;
    token_res_t  push0;
    logic [1:0]  push_cnt;
    token_res_t  head;
    logic        head_vld;
    logic        space2;

    assign ch     = s_tdata;
    assign s_fire = s_tvalid && s_tready;

    always_comb begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        held_next   = held_reg;
        tlen_next   = tlen_reg;
        ttotal_next = ttotal_reg;
        eff_len     = tlen_reg;
        fresh       = 1'b0;
        res_a_vld   = 1'b0;
        res_b_vld   = 1'b0;
        res_a       = '0;
        res_b       = '0;

        if (s_fire) begin
            case (mode_reg)
                MODE_NUMBER: begin
                    if (is_digit(ch)) begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1)
                                 + {24'd0, 8'(ch - CH_ZERO)};
                    end else begin
                        res_a_vld = 1'b1;
                        res_a     = make_res(KIND_NUMBER, acc_reg, CH_NUL, 1'b0, 1'b1, 1'b0);
                        acc_next  = '0;
                        fresh     = 1'b1;
                    end
                end
                MODE_LETTER, MODE_WORD: begin
                    if (mode_reg == MODE_LETTER && !is_alnum(ch)) begin
                        res_a_vld = 1'b1;
                        res_a     = make_res(KIND_VAR, {24'd0, 8'(held_reg - CH_UP_A)},
                                             CH_NUL, 1'b0, 1'b1, 1'b0);
                        fresh     = 1'b1;
                    end else begin
                        // a letter followed by an alphanumeric turns into a word
                        eff_len   = (mode_reg == MODE_LETTER) ? 8'd1 : tlen_reg;
                        res_a_vld = 1'b1;
                        if (is_alnum(ch) && eff_len < TEXT_CAP) begin
                            res_a     = make_res(KIND_WORD, '0, held_reg, 1'b1, 1'b0, 1'b0);
                            held_next = to_upper(ch);
                            tlen_next = 8'(eff_len + 8'd1);
                            mode_next = MODE_WORD;
                        end else begin
                            res_a     = make_res(KIND_WORD, '0, held_reg, 1'b1, 1'b1, 1'b0);
                            tlen_next = '0;
                            fresh     = 1'b1;
                        end
                    end
                end
                MODE_STRING: begin
                    if (ch == CH_QUOTE || ch == CH_NUL || tlen_reg >= TEXT_CAP) begin
                        res_a_vld = 1'b1;
                        res_a     = make_res(KIND_STRING, '0, held_reg, tlen_reg != '0,
                                             1'b1, 1'b0);
                        tlen_next = '0;
                        if (ch == CH_QUOTE) begin
                            mode_next = MODE_IDLE;
                        end else begin
                            fresh = 1'b1;
                        end
                    end else begin
                        // the held character goes out once its successor is known
                        res_a_vld = tlen_reg != '0;
                        res_a     = make_res(KIND_STRING, '0, held_reg, 1'b1, 1'b0, 1'b0);
                        held_next = ch;
                        tlen_next = 8'(tlen_reg + 8'd1);
                    end
                end
                MODE_LT: begin
                    res_a_vld = 1'b1;
                    if (ch == CH_EQ) begin
                        res_a     = make_res(KIND_LE, '0, CH_NUL, 1'b0, 1'b1, 1'b0);
                        mode_next = MODE_IDLE;
                    end else if (ch == CH_GT) begin
                        res_a     = make_res(KIND_NE, '0, CH_NUL, 1'b0, 1'b1, 1'b0);
                        mode_next = MODE_IDLE;
                    end else begin
                        res_a = make_res(KIND_LT, '0, CH_NUL, 1'b0, 1'b1, 1'b0);
                        fresh = 1'b1;
                    end
                end
                MODE_GT: begin
                    res_a_vld = 1'b1;
                    if (ch == CH_EQ) begin
                        res_a     = make_res(KIND_GE, '0, CH_NUL, 1'b0, 1'b1, 1'b0);
                        mode_next = MODE_IDLE;
                    end else begin
                        res_a = make_res(KIND_GT, '0, CH_NUL, 1'b0, 1'b1, 1'b0);
                        fresh = 1'b1;
                    end
                end
                default: begin
                    fresh = 1'b1;
                end
            endcase

            // end line on NUL, skip blank or at token cap, else start a token
            if (fresh) begin
                mode_next = MODE_IDLE;
                if (ch == CH_NUL) begin
                    res_b_vld   = 1'b1;
                    res_b       = make_res(KIND_EOL, '0, CH_NUL, 1'b0, 1'b1, 1'b1);
                    acc_next    = '0;
                    held_next   = '0;
                    tlen_next   = '0;
                    ttotal_next = '0;
                end else if (ch == CH_SPACE || ch == CH_TAB || ttotal_reg >= TOKEN_CAP) begin
                    mode_next = MODE_IDLE;
                end else begin
                    ttotal_next = 7'(ttotal_reg + 7'd1);
                    if (is_digit(ch)) begin
                        mode_next = MODE_NUMBER;
                        acc_next  = {24'd0, 8'(ch - CH_ZERO)};
                    end else if (is_upper(ch)) begin
                        mode_next = MODE_LETTER;
                        held_next = ch;
                    end else if (is_lower(ch)) begin
                        mode_next = MODE_WORD;
                        held_next = to_upper(ch);
                        tlen_next = 8'd1;
                    end else if (ch == CH_QUOTE) begin
                        mode_next = MODE_STRING;
                        tlen_next = '0;
                    end else if (ch == CH_LT) begin
                        mode_next = MODE_LT;
                    end else if (ch == CH_GT) begin
                        mode_next = MODE_GT;
                    end else begin
                        res_b_vld = 1'b1;
                        res_b     = make_res(op_kind(ch), '0, ch, op_kind(ch) == KIND_WORD,
                                             1'b1, 1'b0);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            held_reg   <= '0;
            tlen_reg   <= '0;
            ttotal_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            held_reg   <= held_next;
            tlen_reg   <= tlen_next;
            ttotal_reg <= ttotal_next;
        end
    end

    assign push0    = res_a_vld ? res_a : res_b;
    assign push_cnt = 2'(res_a_vld) + 2'(res_b_vld);

    blt_out_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (res_b),
        .space2   (space2),
        .head     (head),
        .head_vld (head_vld),
        .pop      (m_tvalid && m_tready)
    );

    assign s_tready = space2;
    assign m_tvalid = head_vld;
    assign m_tdata  = {head.text_char, head.value};
    assign m_tuser  = {head.token_last, head.has_char, head.kind};
    assign m_tlast  = head.line_last;

    `BLT_ASSERT_NOW(a_eol_ends_token, m_tvalid && m_tlast, m_tuser[6], "eol result without token_last")
    `BLT_ASSERT_NOW(a_no_char_zero, m_tvalid && !m_tuser[5], m_tdata[39:32] == 8'd0, "stray text char")
    `BLT_ASSERT_NEXT(a_eol_clears, s_fire && ch == CH_NUL, mode_reg == MODE_IDLE && ttotal_reg == '0 && tlen_reg == '0, "line state not cleared")
    `BLT_ASSERT_NOW(a_caps_hold, 1'b1, ttotal_reg <= TOKEN_CAP && tlen_reg <= TEXT_CAP, "cap exceeded")

endmodule

`default_nettype wire
